// ===== rtl/tkmh_pkg.sv =====
// Shared types and constants for the top-K min-heap tracker.
// Holds the slot layout, operation codes and the controller/datapath link.
// No dependencies.
package tkmh_pkg;

  localparam int TOK_W = 16;
  localparam int POS_W = 32;
  localparam int SCR_W = 32;
  localparam int DEFAULT_DEPTH = 16;

  // Configuration register map (word index)
  localparam logic REG_MAX_ENTRIES = 1'b0;
  localparam logic [4:0] MAX_ENTRIES_RST = 5'd16;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [TOK_W-1:0]        tok;
    logic [POS_W-1:0]        pos;
    logic signed [SCR_W-1:0] scr;
  } slot_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic append;
    logic to_root;
    logic set_acc;
    logic rd_up;
    logic rd_slot;
    logic take_slot;
    logic wr_cur;
    logic wr_a_up;
    logic wr_a_dn;
    logic wr_b_dn;
    logic publish;
  } cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    op_t  op;
    logic full;
    logic beats_root;
    logic at_root;
    logic up_swap;
    logic leaf;
    logic pick_l;
    logic pick_r;
  } stat_t;

endpackage

// ===== rtl/tkmh_ctrl.sv =====
// Sequencer for the top-K min-heap tracker: one word at a time, sift-up
// and sift-down steps, result hand-off. Depends on tkmh_pkg.
module tkmh_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tkmh_pkg::stat_t st,
  output tkmh_pkg::cmd_t  cmd
);
  import tkmh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_CHK,
    S_DN_CMP,
    S_RD_WAIT,
    S_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Decode state and status into commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (st.op)
          OP_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_DONE;
          end
          OP_INSERT: begin
            if (!st.full) begin
              cmd.append  = 1'b1;
              cmd.set_acc = 1'b1;
              state_next  = S_UP_CHK;
            end else if (st.beats_root) begin
              cmd.to_root = 1'b1;
              cmd.set_acc = 1'b1;
              state_next  = S_DN_CHK;
            end else begin
              state_next = S_DONE;
            end
          end
          OP_READ: begin
            cmd.rd_slot = 1'b1;
            state_next  = S_RD_WAIT;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_UP_CHK: begin
        if (st.at_root) begin
          cmd.wr_cur = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.rd_up  = 1'b1;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (st.up_swap) begin
          cmd.wr_a_up = 1'b1;
          state_next  = S_UP_CHK;
        end else begin
          cmd.wr_cur = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DN_CHK: begin
        // children are read on the default address path
        if (st.leaf) begin
          cmd.wr_cur = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (st.pick_r) begin
          cmd.wr_b_dn = 1'b1;
          state_next  = S_DN_CHK;
        end else if (st.pick_l) begin
          cmd.wr_a_dn = 1'b1;
          state_next  = S_DN_CHK;
        end else begin
          cmd.wr_cur = 1'b1;
          state_next = S_DONE;
        end
      end
      S_RD_WAIT: begin
        cmd.take_slot = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/tkmh_datapath.sv =====
// Datapath for the top-K min-heap tracker: slot memory, moving entry,
// heap index arithmetic, comparators and result registers. Uses tkmh_pkg.
module tkmh_datapath #(
  parameter int HEAP_DEPTH = tkmh_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tkmh_pkg::cmd_t                    cmd,
  output tkmh_pkg::stat_t                   st,
  input  logic [4:0]                        max_entries,
  input  logic [1:0]                        operation,
  input  logic [tkmh_pkg::TOK_W-1:0]        token,
  input  logic [tkmh_pkg::POS_W-1:0]        position,
  input  logic signed [tkmh_pkg::SCR_W-1:0] score,
  input  logic [3:0]                        read_index,
  output logic                              accepted,
  output logic [4:0]                        entry_count,
  output logic                              slot_valid,
  output logic [tkmh_pkg::TOK_W-1:0]        slot_token,
  output logic [tkmh_pkg::POS_W-1:0]        slot_position,
  output logic signed [tkmh_pkg::SCR_W-1:0] slot_score,
  output logic signed [tkmh_pkg::SCR_W-1:0] lowest_score
);
  import tkmh_pkg::*;

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int PW = AW + 2;
  localparam int XW = (CW > 5) ? CW : 5;

  slot_t mem [HEAP_DEPTH];
  slot_t rda, rdb, cur, wr_data, res_slot;

  logic [CW-1:0] count;
  logic [AW-1:0] at, parent, rd_addr_a, rd_addr_b;
  logic [PW-1:0] left, right, n_ext;
  logic [XW-1:0] limit;
  logic [3:0]    ridx_q;
  op_t           op_q;
  logic          wr_en, lsel, ridx_hit, res_acc, res_valid;
  logic signed [SCR_W-1:0] root_scr, best_scr;

  // Effective K: zero counts as one, clamp to the slot count
  always_comb begin
    if (max_entries == '0) begin
      limit = XW'(1);
    end else if (XW'(max_entries) > XW'(HEAP_DEPTH)) begin
      limit = XW'(HEAP_DEPTH);
    end else begin
      limit = XW'(max_entries);
    end
  end

  // Heap index arithmetic
  assign parent = (at - AW'(1)) >> 1;
  assign left   = {1'b0, at, 1'b1};
  assign right  = left + PW'(1);
  assign n_ext  = PW'(count);

  assign rd_addr_a = cmd.rd_up   ? parent :
                     cmd.rd_slot ? AW'(ridx_q) : left[AW-1:0];
  assign rd_addr_b = right[AW-1:0];

  // Compare the moving entry against parent or children
  assign lsel     = rda.scr < cur.scr;
  assign best_scr = lsel ? rda.scr : cur.scr;
  assign ridx_hit = XW'(ridx_q) < XW'(count);

  always_comb begin
    st.op         = op_q;
    st.full       = XW'(count) >= limit;
    st.beats_root = (count != '0) && (cur.scr > root_scr);
    st.at_root    = (at == '0);
    st.up_swap    = cur.scr < rda.scr;
    st.leaf       = !(left < n_ext);
    st.pick_l     = lsel;
    st.pick_r     = (right < n_ext) && (rdb.scr < best_scr);
  end

  // Write the hole at the current index
  assign wr_en   = cmd.wr_cur | cmd.wr_a_up | cmd.wr_a_dn | cmd.wr_b_dn;
  assign wr_data = cmd.wr_cur ? cur : (cmd.wr_b_dn ? rdb : rda);

  // Slot memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[at] <= wr_data;
    end
    rda <= mem[rd_addr_a];
    rdb <= mem[rd_addr_b];
  end

  // Hold the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.append) begin
      count <= count + CW'(1);
    end
  end

  // Advance the heap index and track the root score
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      at <= AW'(count);
    end else if (cmd.to_root) begin
      at <= '0;
    end else if (cmd.wr_a_up) begin
      at <= parent;
    end else if (cmd.wr_a_dn) begin
      at <= left[AW-1:0];
    end else if (cmd.wr_b_dn) begin
      at <= right[AW-1:0];
    end
    if (wr_en && at == '0) begin
      root_scr <= wr_data.scr;
    end
  end

  // Capture the input word and build the result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur.tok   <= token;
      cur.pos   <= position;
      cur.scr   <= score;
      op_q      <= op_t'(operation);
      ridx_q    <= read_index;
      res_acc   <= 1'b0;
      res_valid <= 1'b0;
      res_slot  <= '0;
    end
    if (cmd.set_acc) begin
      res_acc <= 1'b1;
    end
    if (cmd.take_slot && ridx_hit) begin
      res_valid <= 1'b1;
      res_slot  <= rda;
    end
    if (cmd.publish) begin
      accepted      <= res_acc;
      entry_count   <= 5'(count);
      slot_valid    <= res_valid;
      slot_token    <= res_slot.tok;
      slot_position <= res_slot.pos;
      slot_score    <= res_slot.scr;
      lowest_score  <= (count != '0) ? root_scr : '0;
    end
  end

endmodule

// ===== rtl/top_k_min_heap_tracker_unit.sv =====
// Top level of the top-K min-heap tracker: configuration register,
// sequencer and datapath. Depends on tkmh_pkg, tkmh_ctrl, tkmh_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word: operation, token,
//   position, score, read_index. Operations: clear, insert, read slot.
//   Output channel (out_valid/out_ready) returns one word per input word.
//   max_entries (APB word 0) sets K; write it only while the block is idle.
//   Clear, unknown operations and rejected inserts go from the decide step
//   straight to the hand-off step; a read passes through a wait step that
//   takes the slot; an insert walks sift-up or sift-down, one heap level at
//   a time. The walk is set by the slot memory: each level reads parent or
//   both children, then writes. One word is in work at a time; in_ready is
//   high only while idle, so the next word is accepted only after the result
//   of the previous word has been raised.
//   A finished result sits in the output register while the next word is
//   accepted; a stalled receiver holds the sequencer at its hand-off step.
//   Reset empties the heap, sets K to 16 and drops any pending result.
//   Slot memory contents are not cleared; only slots below the count are read.
module top_k_min_heap_tracker_unit #(
  parameter int HEAP_DEPTH = tkmh_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        operation,
  input  logic [tkmh_pkg::TOK_W-1:0]        token,
  input  logic [tkmh_pkg::POS_W-1:0]        position,
  input  logic signed [tkmh_pkg::SCR_W-1:0] score,
  input  logic [3:0]                        read_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              accepted,
  output logic [4:0]                        entry_count,
  output logic                              slot_valid,
  output logic [tkmh_pkg::TOK_W-1:0]        slot_token,
  output logic [tkmh_pkg::POS_W-1:0]        slot_position,
  output logic signed [tkmh_pkg::SCR_W-1:0] slot_score,
  output logic signed [tkmh_pkg::SCR_W-1:0] lowest_score,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import tkmh_pkg::*;

  logic [4:0] max_entries;
  cmd_t       cmd;
  stat_t      st;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_ENTRIES) ? {27'b0, max_entries} : 32'b0;

  // Write the K register on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_ENTRIES) begin
      max_entries <= pwdata[4:0];
    end
  end

  tkmh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  tkmh_datapath #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .max_entries   (max_entries),
    .operation     (operation),
    .token         (token),
    .position      (position),
    .score         (score),
    .read_index    (read_index),
    .accepted      (accepted),
    .entry_count   (entry_count),
    .slot_valid    (slot_valid),
    .slot_token    (slot_token),
    .slot_position (slot_position),
    .slot_score    (slot_score),
    .lowest_score  (lowest_score)
  );

endmodule

// ===== rtl/tkmh_checker.sv =====
// Port-level checks for the top-K min-heap tracker, bound to the top level.
// Depends on tkmh_pkg and top_k_min_heap_tracker_unit.
module tkmh_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              accepted,
  input logic [4:0]                        entry_count,
  input logic                              slot_valid,
  input logic [tkmh_pkg::TOK_W-1:0]        slot_token,
  input logic [tkmh_pkg::POS_W-1:0]        slot_position,
  input logic signed [tkmh_pkg::SCR_W-1:0] slot_score,
  input logic signed [tkmh_pkg::SCR_W-1:0] lowest_score
);
  import tkmh_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(accepted) && $stable(entry_count)
      && $stable(slot_valid) && $stable(slot_token) && $stable(slot_position)
      && $stable(slot_score) && $stable(lowest_score))
    else $error("result word changed while stalled");

  // One word in work at a time
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in work");

  // Reset drops the result and opens the input
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // An accepted insert leaves a non-empty heap and no slot data
  a_insert_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> entry_count != 5'd0 && !slot_valid && slot_token == '0
      && slot_position == '0 && slot_score == '0)
    else $error("insert result inconsistent");

endmodule

bind top_k_min_heap_tracker_unit tkmh_checker u_tkmh_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .accepted      (accepted),
  .entry_count   (entry_count),
  .slot_valid    (slot_valid),
  .slot_token    (slot_token),
  .slot_position (slot_position),
  .slot_score    (slot_score),
  .lowest_score  (lowest_score)
);
